// File: sv/p15chk_pkg.sv
// ----------------------------------------------------------------------------
// p15chk_pkg
// Shared types and constants for the PRBS-15 page pattern checker.
// ----------------------------------------------------------------------------
package p15chk_pkg;

  localparam int unsigned PAGE_SIZE = 256;
  localparam int unsigned POS_W     = $clog2(PAGE_SIZE);

  localparam int unsigned PAGE_W    = 15;
  localparam int unsigned SREG_W    = 15;
  localparam int unsigned CNT_W     = 9;
  localparam int unsigned PAGES_W   = 16;
  localparam int unsigned BYTES_W   = 24;

  localparam logic [SREG_W-1:0]  SEED_TOP     = 15'h4000;
  localparam logic [SREG_W-1:0]  SEED_MASK    = 15'h3FFF;
  localparam logic [CNT_W-1:0]   PAGE_CNT_MAX = 9'h1FF;
  localparam logic [PAGES_W-1:0] PAGES_MAX    = 16'hFFFF;
  localparam logic [BYTES_W-1:0] BYTES_MAX    = 24'hFFFFFF;
  localparam logic [POS_W-1:0]   POS_LAST     = POS_W'(PAGE_SIZE - 1);

  typedef struct packed {
    logic [PAGE_W-1:0] page_number;
    logic [7:0]        read_byte;
    logic              clear_totals;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         expected_byte;
    logic               mismatch;
    logic               page_done;
    logic [CNT_W-1:0]   page_bad_bytes;
    logic [PAGES_W-1:0] bad_pages_total;
    logic [BYTES_W-1:0] bad_bytes_total;
  } out_item_t;

endpackage

// File: sv/p15chk_if.sv
// ----------------------------------------------------------------------------
// p15chk_in_if / p15chk_out_if
// Valid/ready channels for read-back beats and check results.
// ----------------------------------------------------------------------------
interface p15chk_in_if;
  logic                 valid;
  logic                 ready;
  p15chk_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface p15chk_out_if;
  logic                  valid;
  logic                  ready;
  p15chk_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/p15chk_lfsr8.sv
// ----------------------------------------------------------------------------
// p15chk_lfsr8
// Eight unrolled steps of the x^15+x^14+1 generator, one pattern byte out.
// ----------------------------------------------------------------------------
module p15chk_lfsr8 (
  input  logic [p15chk_pkg::SREG_W-1:0] sreg_in,
  output logic [7:0]                    pattern_byte,
  output logic [p15chk_pkg::SREG_W-1:0] sreg_out
);

  always_comb begin
    logic [p15chk_pkg::SREG_W-1:0] s;
    logic [7:0]                    acc;
    s   = sreg_in;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      // emitted bit is taken before the shift, MSB first
      acc = {acc[6:0], s[14]};
      s   = {s[13:0], s[14] ^ s[13]};
    end
    pattern_byte = acc;
    sreg_out     = s;
  end

endmodule

// File: sv/prbs15_page_pattern_checker_unit.sv
// ----------------------------------------------------------------------------
// prbs15_page_pattern_checker_unit
// Per-page PRBS-15 expected-byte generator and read-back checker.
// Result registered: valid in the cycle after the beat is accepted.
// Throughput: one beat per cycle while results are taken; the 8-step LFSR
// unroll and total add/saturate sit between accept and the result register.
// Reset: synchronous active-low; clears generator, position, page count,
// run totals and the result valid flag.
// ----------------------------------------------------------------------------
module prbs15_page_pattern_checker_unit (
  input logic          clk,
  input logic          rst_n,
  p15chk_in_if.sink    in_bus,
  p15chk_out_if.source out_bus
);

  logic [p15chk_pkg::SREG_W-1:0]  sreg_r, sreg_nxt;
  logic [p15chk_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [p15chk_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [p15chk_pkg::PAGES_W-1:0] pages_r, pages_nxt;
  logic [p15chk_pkg::BYTES_W-1:0] bytes_r, bytes_nxt;
  logic                           out_valid_r;
  p15chk_pkg::out_item_t          out_data_r, out_data_nxt;

  logic                           accept;
  logic [p15chk_pkg::POS_W-1:0]   pos_eff;
  logic                           start;
  logic                           done;
  logic [p15chk_pkg::SREG_W-1:0]  sreg_in;
  logic [p15chk_pkg::SREG_W-1:0]  sreg_step;
  logic [7:0]                     pattern_byte;
  logic                           miss;
  logic [p15chk_pkg::CNT_W-1:0]   cnt_base;
  logic [p15chk_pkg::PAGES_W-1:0] pages_base;
  logic [p15chk_pkg::BYTES_W-1:0] bytes_base;
  logic [p15chk_pkg::BYTES_W:0]   bytes_sum;

  assign in_bus.ready  = !out_valid_r || out_bus.ready;
  assign accept        = in_bus.valid && in_bus.ready;
  assign out_bus.valid = out_valid_r;
  assign out_bus.data  = out_data_r;

  p15chk_lfsr8 u_lfsr8 (
    .sreg_in      (sreg_in),
    .pattern_byte (pattern_byte),
    .sreg_out     (sreg_step)
  );

  always_comb begin
    // clear restarts the page and zeroes totals before this beat counts
    pos_eff    = in_bus.data.clear_totals ? '0 : pos_r;
    pages_base = in_bus.data.clear_totals ? '0 : pages_r;
    bytes_base = in_bus.data.clear_totals ? '0 : bytes_r;
    start      = (pos_eff == '0);
    done       = (pos_eff == p15chk_pkg::POS_LAST);

    sreg_in  = start ? (p15chk_pkg::SEED_TOP |
                        (in_bus.data.page_number & p15chk_pkg::SEED_MASK))
                     : sreg_r;
    cnt_base = start ? '0 : cnt_r;

    miss    = (in_bus.data.read_byte != pattern_byte);
    cnt_nxt = (miss && cnt_base != p15chk_pkg::PAGE_CNT_MAX) ? cnt_base + 1'b1 : cnt_base;

    bytes_sum = {1'b0, bytes_base} + {{(p15chk_pkg::BYTES_W + 1 - p15chk_pkg::CNT_W){1'b0}},
                                      cnt_nxt};
    if (done) begin
      pages_nxt = (cnt_nxt != '0 && pages_base != p15chk_pkg::PAGES_MAX)
                  ? pages_base + 1'b1 : pages_base;
      bytes_nxt = bytes_sum[p15chk_pkg::BYTES_W] ? p15chk_pkg::BYTES_MAX
                                                 : bytes_sum[p15chk_pkg::BYTES_W-1:0];
      pos_nxt   = '0;
    end else begin
      pages_nxt = pages_base;
      bytes_nxt = bytes_base;
      pos_nxt   = pos_eff + 1'b1;
    end
    sreg_nxt = sreg_step;

    out_data_nxt.expected_byte   = pattern_byte;
    out_data_nxt.mismatch        = miss;
    out_data_nxt.page_done       = done;
    out_data_nxt.page_bad_bytes  = cnt_nxt;
    out_data_nxt.bad_pages_total = pages_nxt;
    out_data_nxt.bad_bytes_total = bytes_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sreg_r      <= '0;
      pos_r       <= '0;
      cnt_r       <= '0;
      pages_r     <= '0;
      bytes_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        sreg_r  <= sreg_nxt;
        pos_r   <= pos_nxt;
        cnt_r   <= cnt_nxt;
        pages_r <= pages_nxt;
        bytes_r <= bytes_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// File: tb/sv/p15chk_readback_checker.sv
// ----------------------------------------------------------------------------
// p15chk_readback_checker
// Passive checker for the PRBS-15 page pattern checker. Watches both
// channels, keeps its own pattern generator, page counter and run totals,
// and compares every result beat field by field against the oldest
// prediction. Reports the failure count and the predictions still pending.
// ----------------------------------------------------------------------------
module p15chk_readback_checker (
  input  logic         clk,
  input  logic         rst_n,
  p15chk_in_if         in_mon,
  p15chk_out_if        out_mon,
  output int unsigned  fail_count,
  output int unsigned  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import p15chk_pkg::*;

  logic [SREG_W-1:0]  lfsr;
  int unsigned        page_pos;
  logic [CNT_W-1:0]   page_errs;
  logic [PAGES_W-1:0] pages_failed;
  logic [BYTES_W-1:0] bytes_failed;

  out_item_t   predicted_q[$];
  int unsigned n_fail = 0;
  int unsigned n_pending = 0;

  assign fail_count = n_fail;
  assign pending    = n_pending;

  function automatic out_item_t predict_check(in_item_t beat);
    out_item_t r;
    logic [7:0] pat;
    logic       miss;
    logic       last;
    pat = '0;
    if (beat.clear_totals) begin
      pages_failed = '0;
      bytes_failed = '0;
      page_pos     = 0;
    end
    if (page_pos == 0) begin
      lfsr      = SEED_TOP | (beat.page_number & SEED_MASK);
      page_errs = '0;
    end
    // eight steps per byte, emitted bit taken before the shift
    for (int k = 0; k < 8; k++) begin
      pat  = {pat[6:0], lfsr[SREG_W-1]};
      lfsr = {lfsr[SREG_W-2:0], lfsr[SREG_W-1] ^ lfsr[SREG_W-2]};
    end
    miss = (beat.read_byte != pat);
    if (miss && page_errs != PAGE_CNT_MAX) page_errs = page_errs + 1'b1;
    last = (page_pos == PAGE_SIZE - 1);
    if (last) begin
      if (page_errs != '0 && pages_failed != PAGES_MAX) pages_failed = pages_failed + 1'b1;
      if (BYTES_W'(page_errs) > BYTES_MAX - bytes_failed) bytes_failed = BYTES_MAX;
      else bytes_failed = bytes_failed + BYTES_W'(page_errs);
      page_pos = 0;
    end else begin
      page_pos = page_pos + 1;
    end
    r.expected_byte   = pat;
    r.mismatch        = miss;
    r.page_done       = last;
    r.page_bad_bytes  = page_errs;
    r.bad_pages_total = pages_failed;
    r.bad_bytes_total = bytes_failed;
    return r;
  endfunction

  task automatic note_failure(string what, logic [31:0] exp_v, logic [31:0] act_v);
    if (n_fail < 10)
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, what, exp_v, act_v);
    n_fail++;
  endtask

  task automatic compare_result(out_item_t exp_r, out_item_t act_r);
    if (act_r.expected_byte !== exp_r.expected_byte)
      note_failure("expected_byte", 32'(exp_r.expected_byte), 32'(act_r.expected_byte));
    if (act_r.mismatch !== exp_r.mismatch)
      note_failure("mismatch", 32'(exp_r.mismatch), 32'(act_r.mismatch));
    if (act_r.page_done !== exp_r.page_done)
      note_failure("page_done", 32'(exp_r.page_done), 32'(act_r.page_done));
    if (act_r.page_bad_bytes !== exp_r.page_bad_bytes)
      note_failure("page_bad_bytes", 32'(exp_r.page_bad_bytes), 32'(act_r.page_bad_bytes));
    if (act_r.bad_pages_total !== exp_r.bad_pages_total)
      note_failure("bad_pages_total", 32'(exp_r.bad_pages_total),
                   32'(act_r.bad_pages_total));
    if (act_r.bad_bytes_total !== exp_r.bad_bytes_total)
      note_failure("bad_bytes_total", 32'(exp_r.bad_bytes_total),
                   32'(act_r.bad_bytes_total));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      lfsr         = '0;
      page_pos     = 0;
      page_errs    = '0;
      pages_failed = '0;
      bytes_failed = '0;
      predicted_q.delete();
    end else begin
      // push before pop so a same-cycle result would still find its entry
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1)
        predicted_q.push_back(predict_check(in_mon.data));
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        if (predicted_q.size() == 0) begin
          if (n_fail < 10)
            $display("%0t: result beat with nothing expected: 0x%0h", $realtime,
                     out_mon.data);
          n_fail++;
        end else begin
          compare_result(predicted_q.pop_front(), out_mon.data);
        end
      end
    end
    n_pending = predicted_q.size();
  end

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for prbs15_page_pattern_checker_unit. A short directed
// run hits seed extremes, aliasing, mid-page page changes and clears; then
// whole pages of read-back beats follow, clean, lightly corrupted, noisy or
// all bytes flipped, some cut short by a clear. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import p15chk_pkg::*;

  typedef enum int {FILL_CLEAN, FILL_SPARSE, FILL_NOISE, FILL_INVERTED} page_fill_t;

  localparam int unsigned BEAT_TARGET = 1100;

  logic clk = 1'b0;
  logic rst_n;
  bit   steady = 1'b0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned n_sent = 0;

  // stimulus-side pattern tracking, used only to build matching read bytes
  logic [SREG_W-1:0] gen_reg = '0;
  int unsigned       gen_pos = 0;

  p15chk_in_if  in_bus ();
  p15chk_out_if out_bus ();

  prbs15_page_pattern_checker_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  p15chk_readback_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAIL prbs15_page_pattern_checker_unit");
    $finish;
  end

  // result-side backpressure
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!steady && $urandom_range(0, 7) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_beat(in_item_t beat);
    if (!steady && $urandom_range(0, 5) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.data  <= beat;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
    n_sent++;
    @(negedge clk);
  endtask

  // raw < 0: send the correct pattern byte xor flip; otherwise send raw
  task automatic send_read(logic [PAGE_W-1:0] page, logic clr, logic [7:0] flip, int raw);
    in_item_t   beat;
    logic [7:0] good;
    good = '0;
    if (clr) gen_pos = 0;
    if (gen_pos == 0) gen_reg = {1'b1, page[13:0]};
    for (int k = 0; k < 8; k++) begin
      good    = {good[6:0], gen_reg[SREG_W-1]};
      gen_reg = {gen_reg[SREG_W-2:0], gen_reg[SREG_W-1] ^ gen_reg[SREG_W-2]};
    end
    gen_pos = (gen_pos == PAGE_SIZE - 1) ? 0 : gen_pos + 1;
    beat.page_number  = page;
    beat.read_byte    = (raw < 0) ? (good ^ flip) : 8'(raw);
    beat.clear_totals = clr;
    send_beat(beat);
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    page_fill_t        fill;
    logic [PAGE_W-1:0] page;
    logic [PAGE_W-1:0] pg;
    logic [7:0]        flip;
    int                raw;
    int unsigned       cut;
    int unsigned       page_idx;
    bit                need_clear;
    bit                drift;
    bit                clr_start;

    rst_n        = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.data  = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: first page starts from reset without a clear
    send_read(15'h0000, 1'b0, 8'h00, -1);
    send_read(15'h7FFF, 1'b0, 8'h80, -1);   // page ignored mid-page
    send_read(15'h2AAA, 1'b0, 8'h00, 8'h00);
    send_read(15'h5555, 1'b0, 8'h00, 8'hFF);
    send_read(15'h0000, 1'b0, 8'h01, -1);
    send_read(15'h7FFF, 1'b1, 8'h00, -1);
    send_read(15'h0000, 1'b0, 8'hFF, -1);
    send_read(15'h3FFF, 1'b1, 8'h00, -1);   // same seed as 0x7FFF
    send_read(15'h3FFF, 1'b0, 8'h00, -1);
    send_read(15'h4000, 1'b1, 8'h00, 8'hFF); // same seed as page 0
    send_read(15'h0000, 1'b1, 8'h00, 8'h00);
    send_read(15'h2AAA, 1'b1, 8'h55, -1);
    send_read(15'h5555, 1'b0, 8'hAA, -1);
    send_read(15'h5555, 1'b1, 8'h00, -1);
    send_read(15'h1234, 1'b0, 8'h00, -1);
    wait_drained();

    // random whole pages
    need_clear = 1'b1;
    page_idx   = 0;
    while (n_sent < BEAT_TARGET) begin
      case ($urandom_range(0, 7))
        0:       page = '0;
        1:       page = '1;
        default: page = PAGE_W'($urandom_range(0, 32767));
      endcase
      fill      = page_fill_t'(page_idx % 4);
      cut       = (page_idx >= 4 && $urandom_range(0, 3) == 0) ?
                  $urandom_range(1, PAGE_SIZE - 1) : PAGE_SIZE;
      drift     = 1'($urandom_range(0, 1));
      clr_start = need_clear || $urandom_range(0, 5) == 0;
      for (int unsigned b = 0; b < cut && n_sent < BEAT_TARGET; b++) begin
        pg   = (b != 0 && drift) ? PAGE_W'($urandom_range(0, 32767)) : page;
        flip = 8'h00;
        raw  = -1;
        case (fill)
          FILL_SPARSE:   if ($urandom_range(0, 15) == 0) flip = 8'($urandom_range(1, 255));
          FILL_NOISE:    raw = $urandom_range(0, 255);
          FILL_INVERTED: flip = 8'($urandom_range(1, 255));
          default:       flip = 8'h00;
        endcase
        if (n_sent >= 900) steady = 1'b1;
        send_read(pg, (b == 0) && clr_start, flip, raw);
      end
      // a cut page leaves the block mid-page; realign with a clear
      need_clear = (cut < PAGE_SIZE);
      page_idx++;
      if ($urandom_range(0, 2) == 0) wait_drained();
    end
    in_bus.valid <= 1'b0;

    repeat (20000) begin
      if (pending == 0) break;
      @(negedge clk);
    end
    repeat (4) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("PASS prbs15_page_pattern_checker_unit");
    end else begin
      $display("FAIL prbs15_page_pattern_checker_unit");
    end
    $finish;
  end

endmodule

// File: prbs15_page_pattern_checker_unit.f
sv/p15chk_pkg.sv
sv/p15chk_if.sv
sv/p15chk_lfsr8.sv
sv/prbs15_page_pattern_checker_unit.sv
tb/sv/p15chk_readback_checker.sv
tb/sv/tb_top.sv
